/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* rtl/pcs_pkg.sv */
// Package for the point cluster statistics block: defaults, codes and types
package pcs_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int ID_W            = 16;
    localparam int STATUS_W        = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SINGLE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD_I,
        S_LD_I,
        S_RD_J,
        S_LD_J,
        S_SQX,
        S_SQY,
        S_SQSUM,
        S_ROOT,
        S_NEXT,
        S_PAIRS,
        S_DIV_LD,
        S_DIV,
        S_DIV_ST,
        S_OUT
    } pcs_state_t;

    typedef enum logic [2:0] {
        DIV_MAG,
        DIV_AZI,
        DIV_X,
        DIV_Y,
        DIV_DIST
    } pcs_div_sel_t;

endpackage

/* rtl/point_cluster_statistics.sv */
// Top level of the point cluster statistics block
//
// channel | dir | handshake          | payload
// s_      | in  | s_valid / s_ready  | x, y, magnitude, azimuth, last flag
// m_      | out | m_valid / m_ready  | id, count, means, centroid, extents, distance, status
//
// A point that does not close the cluster is taken while the block stays idle.
// The closing point starts the pair pass, which is paced for each pair by the shared square,
// bit-serial root and single RAM read port, then five restoring divisions (four for a single
// point) run one after another in one shared divider.
// s_ready is low from the closing point until its result enters the output register.
// Synchronous active-low reset clears the accumulators, the cluster id and the sequencer.
module point_cluster_statistics
    import pcs_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COORD_WIDTH-1:0]          s_x_coord,
    input  logic signed [COORD_WIDTH-1:0]          s_y_coord,
    input  logic signed [pcs_pkg::FIELD_W-1:0]     s_point_magnitude,
    input  logic signed [pcs_pkg::FIELD_W-1:0]     s_point_azimuth,
    input  logic                                   s_last_point,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [pcs_pkg::ID_W-1:0]               m_cluster_number,
    output logic [$clog2(MAX_POINTS+1)-1:0]        m_point_total,
    output logic signed [pcs_pkg::FIELD_W-1:0]     m_mean_magnitude,
    output logic signed [pcs_pkg::FIELD_W-1:0]     m_mean_azimuth,
    output logic signed [COORD_WIDTH-1:0]          m_centroid_x,
    output logic signed [COORD_WIDTH-1:0]          m_centroid_y,
    output logic [COORD_WIDTH-1:0]                 m_extent_x,
    output logic [COORD_WIDTH-1:0]                 m_extent_y,
    output logic [COORD_WIDTH:0]                   m_mean_pair_distance,
    output logic [pcs_pkg::STATUS_W-1:0]           m_status
);
    import pcs_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int SUM_W  = CW + CNT_W;
    localparam int MSUM_W = FIELD_W + CNT_W;
    localparam int SQ_W   = 2 * CW + 1;
    localparam int ROOT_W = CW + 1;
    localparam int DSUM_W = CW + 1 + 2 * CNT_W;
    localparam int PAIR_W = 2 * CNT_W;
    localparam int DIV_W  = (DSUM_W > MSUM_W) ? DSUM_W : MSUM_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam logic signed [CW-1:0] COORD_TOP = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_BOT = {1'b1, {(CW-1){1'b0}}};

    pcs_state_t   state_reg, state_next;
    pcs_div_sel_t sel_reg;

    // accumulators
    logic [CNT_W-1:0]         count_reg;
    logic                     overflow_reg;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic signed [MSUM_W-1:0] sum_mag_reg, sum_azi_reg;
    logic signed [CW-1:0]     min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [ID_W-1:0]          id_reg;

    // pair pass
    logic [IDX_W-1:0]         i_reg, j_reg;
    logic signed [CW-1:0]     xi_reg, yi_reg;
    logic [CW-1:0]            dx_reg, dy_reg;
    logic [2*CW-1:0]          prod_reg;
    logic [SQ_W-1:0]          rem_reg, root_reg, bit_reg;
    logic [DSUM_W-1:0]        dsum_reg;
    logic [PAIR_W-1:0]        pairs_reg;

    // divider
    logic [DIV_W-1:0]         q_reg, drem_reg, dvs_reg;
    logic                     neg_reg;
    logic [DCNT_W-1:0]        dcnt_reg;

    // results
    logic signed [FIELD_W-1:0] res_mag_reg, res_azi_reg;
    logic signed [CW-1:0]      res_x_reg, res_y_reg;
    logic [ROOT_W-1:0]         res_dist_reg;

    logic                      m_valid_reg;

    // RAM
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [2*CW-1:0]        ram_rdata;

    logic                   accept, has_room, out_free, last_pair;
    logic [CNT_W-1:0]       cnt_m1;
    logic signed [CW-1:0]   xj, yj;
    logic [CW-1:0]          mul_in;
    logic [2*CW-1:0]        mul_out;
    logic [SQ_W-1:0]        root_try;
    logic [DIV_W:0]         drem_sh;
    logic                   dbit;
    logic signed [DIV_W-1:0] dvd_s;
    logic [DIV_W-1:0]       q_signed;
    logic [2*CNT_W-1:0]     n_prod;

    pcs_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({s_x_coord, s_y_coord}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign has_room  = (count_reg != CNT_W'(MAX_POINTS));
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign last_pair = (CNT_W'(i_reg) + CNT_W'(1)) == cnt_m1;
    assign xj        = ram_rdata[2*CW-1:CW];
    assign yj        = ram_rdata[CW-1:0];
    assign mul_in    = (state_reg == S_SQX) ? dx_reg : dy_reg;
    assign mul_out   = mul_in * mul_in;
    assign root_try  = root_reg + bit_reg;
    assign drem_sh   = {drem_reg, q_reg[DIV_W-1]};
    assign dbit      = drem_sh >= {1'b0, dvs_reg};
    assign q_signed  = neg_reg ? (~q_reg + DIV_W'(1)) : q_reg;
    assign n_prod    = (2*CNT_W)'(count_reg) * (2*CNT_W)'(cnt_m1);

    always_comb begin
        unique case (sel_reg)
            DIV_MAG: dvd_s = DIV_W'(sum_mag_reg);
            DIV_AZI: dvd_s = DIV_W'(sum_azi_reg);
            DIV_X:   dvd_s = DIV_W'(sum_x_reg);
            DIV_Y:   dvd_s = DIV_W'(sum_y_reg);
            default: dvd_s = $signed(DIV_W'(dsum_reg));
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept && s_last_point) state_next = S_START;
            S_START:  state_next = (count_reg > CNT_W'(1)) ? S_RD_I : S_PAIRS;
            S_RD_I:   state_next = S_LD_I;
            S_LD_I:   state_next = S_LD_J;
            S_RD_J:   state_next = S_LD_J;
            S_LD_J:   state_next = S_SQX;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_SQSUM;
            S_SQSUM:  state_next = S_ROOT;
            S_ROOT:   if (bit_reg[0]) state_next = S_NEXT;
            S_NEXT: begin
                if (CNT_W'(j_reg) == cnt_m1) begin
                    state_next = last_pair ? S_PAIRS : S_RD_I;
                end else begin
                    state_next = S_RD_J;
                end
            end
            S_PAIRS:  state_next = S_DIV_LD;
            S_DIV_LD: state_next = S_DIV;
            S_DIV:    if (dcnt_reg == '0) state_next = S_DIV_ST;
            S_DIV_ST: begin
                if (sel_reg == DIV_DIST || (sel_reg == DIV_Y && pairs_reg == '0)) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_DIV_LD;
                end
            end
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        ram_we    = accept && has_room;
        ram_raddr = (state_reg == S_RD_I) ? i_reg : j_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_mag_reg  <= '0;
            sum_azi_reg  <= '0;
            min_x_reg    <= COORD_TOP;
            min_y_reg    <= COORD_TOP;
            max_x_reg    <= COORD_BOT;
            max_y_reg    <= COORD_BOT;
            id_reg       <= '0;
            m_valid_reg  <= 1'b0;
            sel_reg      <= DIV_MAG;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (has_room) begin
                            count_reg   <= count_reg + CNT_W'(1);
                            sum_x_reg   <= sum_x_reg + SUM_W'(s_x_coord);
                            sum_y_reg   <= sum_y_reg + SUM_W'(s_y_coord);
                            sum_mag_reg <= sum_mag_reg + MSUM_W'(s_point_magnitude);
                            sum_azi_reg <= sum_azi_reg + MSUM_W'(s_point_azimuth);
                            if (s_x_coord < min_x_reg) min_x_reg <= s_x_coord;
                            if (s_x_coord > max_x_reg) max_x_reg <= s_x_coord;
                            if (s_y_coord < min_y_reg) min_y_reg <= s_y_coord;
                            if (s_y_coord > max_y_reg) max_y_reg <= s_y_coord;
                        end else begin
                            overflow_reg <= 1'b1;
                        end
                    end
                end
                S_START: begin
                    i_reg    <= '0;
                    j_reg    <= IDX_W'(1);
                    dsum_reg <= '0;
                    sel_reg  <= DIV_MAG;
                end
                S_LD_I: begin
                    xi_reg <= xj;
                    yi_reg <= yj;
                end
                S_LD_J: begin
                    dx_reg <= (xi_reg >= xj) ? CW'(xi_reg - xj) : CW'(xj - xi_reg);
                    dy_reg <= (yi_reg >= yj) ? CW'(yi_reg - yj) : CW'(yj - yi_reg);
                end
                S_SQX: begin
                    prod_reg <= mul_out;
                end
                S_SQY: begin
                    rem_reg  <= SQ_W'(prod_reg);
                    prod_reg <= mul_out;
                end
                S_SQSUM: begin
                    rem_reg  <= rem_reg + SQ_W'(prod_reg);
                    root_reg <= '0;
                    bit_reg  <= SQ_W'(1) << (2 * CW);
                end
                S_ROOT: begin
                    if (rem_reg >= root_try) begin
                        rem_reg  <= rem_reg - root_try;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                S_NEXT: begin
                    dsum_reg <= dsum_reg + DSUM_W'(root_reg[ROOT_W-1:0]);
                    if (CNT_W'(j_reg) == cnt_m1) begin
                        i_reg <= i_reg + IDX_W'(1);
                        j_reg <= i_reg + IDX_W'(2);
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                S_PAIRS: begin
                    pairs_reg    <= PAIR_W'(n_prod >> 1);
                    res_dist_reg <= '0;
                end
                S_DIV_LD: begin
                    neg_reg  <= dvd_s[DIV_W-1];
                    q_reg    <= dvd_s[DIV_W-1] ? DIV_W'(-dvd_s) : DIV_W'(dvd_s);
                    drem_reg <= '0;
                    dvs_reg  <= (sel_reg == DIV_DIST) ? DIV_W'(pairs_reg) : DIV_W'(count_reg);
                    dcnt_reg <= DCNT_W'(DIV_W - 1);
                end
                S_DIV: begin
                    drem_reg <= dbit ? DIV_W'(drem_sh - {1'b0, dvs_reg}) : drem_sh[DIV_W-1:0];
                    q_reg    <= {q_reg[DIV_W-2:0], dbit};
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                end
                S_DIV_ST: begin
                    unique case (sel_reg)
                        DIV_MAG: begin
                            res_mag_reg <= q_signed[FIELD_W-1:0];
                            sel_reg     <= DIV_AZI;
                        end
                        DIV_AZI: begin
                            res_azi_reg <= q_signed[FIELD_W-1:0];
                            sel_reg     <= DIV_X;
                        end
                        DIV_X: begin
                            res_x_reg <= q_signed[CW-1:0];
                            sel_reg   <= DIV_Y;
                        end
                        DIV_Y: begin
                            res_y_reg <= q_signed[CW-1:0];
                            sel_reg   <= DIV_DIST;
                        end
                        default: begin
                            res_dist_reg <= q_reg[ROOT_W-1:0];
                        end
                    endcase
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_cluster_number     <= id_reg;
                        m_point_total        <= count_reg;
                        m_mean_magnitude     <= res_mag_reg;
                        m_mean_azimuth       <= res_azi_reg;
                        m_centroid_x         <= res_x_reg;
                        m_centroid_y         <= res_y_reg;
                        m_extent_x           <= CW'(max_x_reg - min_x_reg);
                        m_extent_y           <= CW'(max_y_reg - min_y_reg);
                        m_mean_pair_distance <= res_dist_reg;
                        if (overflow_reg) begin
                            m_status <= STATUS_OVERFLOW;
                        end else if (count_reg == CNT_W'(1)) begin
                            m_status <= STATUS_SINGLE;
                        end else begin
                            m_status <= STATUS_OK;
                        end
                        id_reg       <= id_reg + ID_W'(1);
                        count_reg    <= '0;
                        overflow_reg <= 1'b0;
                        sum_x_reg    <= '0;
                        sum_y_reg    <= '0;
                        sum_mag_reg  <= '0;
                        sum_azi_reg  <= '0;
                        min_x_reg    <= COORD_TOP;
                        min_y_reg    <= COORD_TOP;
                        max_x_reg    <= COORD_BOT;
                        max_y_reg    <= COORD_BOT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/pcs_ram.sv */
// Generic single write port, single read port RAM with registered read
module pcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/pcs_checker.sv */
// Port-level checker for the point cluster statistics block, with its bind
`include "assert_macros.svh"

module pcs_checker
    import pcs_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic signed [COORD_WIDTH-1:0]          s_x_coord,
    input logic signed [COORD_WIDTH-1:0]          s_y_coord,
    input logic signed [pcs_pkg::FIELD_W-1:0]     s_point_magnitude,
    input logic signed [pcs_pkg::FIELD_W-1:0]     s_point_azimuth,
    input logic                                   s_last_point,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic [pcs_pkg::ID_W-1:0]               m_cluster_number,
    input logic [$clog2(MAX_POINTS+1)-1:0]        m_point_total,
    input logic signed [pcs_pkg::FIELD_W-1:0]     m_mean_magnitude,
    input logic signed [pcs_pkg::FIELD_W-1:0]     m_mean_azimuth,
    input logic signed [COORD_WIDTH-1:0]          m_centroid_x,
    input logic signed [COORD_WIDTH-1:0]          m_centroid_y,
    input logic [COORD_WIDTH-1:0]                 m_extent_x,
    input logic [COORD_WIDTH-1:0]                 m_extent_y,
    input logic [COORD_WIDTH:0]                   m_mean_pair_distance,
    input logic [pcs_pkg::STATUS_W-1:0]           m_status
);
    import pcs_pkg::*;

    `ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_valid)
    `ASSERT_RST(a_valid_held, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `ASSERT_RST(a_id_held, aclk, aresetn, m_valid && !m_ready |=> $stable(m_cluster_number))
    `ASSERT_RST(a_single_point, aclk, aresetn, m_valid && m_status == STATUS_SINGLE |-> m_point_total == 1 && m_mean_pair_distance == 0)
    `ASSERT_RST(a_one_point_no_extent, aclk, aresetn, m_valid && m_point_total == 1 |-> m_extent_x == 0 && m_extent_y == 0)

endmodule

bind point_cluster_statistics pcs_checker #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
) u_pcs_checker (.*);

/* tb/sv/point_cluster_statistics_tb.sv */
// Testbench for point_cluster_statistics: checks cluster results against a built-in predictor
`timescale 1ns / 1ps

module point_cluster_statistics_tb;
    import pcs_pkg::*;

    localparam int NPTS = 64;
    localparam int CW = 16;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [15:0] cluster_number;
        logic [6:0]  point_total;
        logic [15:0] mean_magnitude;
        logic [15:0] mean_azimuth;
        logic [15:0] centroid_x;
        logic [15:0] centroid_y;
        logic [15:0] extent_x;
        logic [15:0] extent_y;
        logic [16:0] mean_pair_distance;
        logic [1:0]  status;
    } cluster_stats_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_x_coord = '0;
    logic signed [15:0] s_y_coord = '0;
    logic signed [15:0] s_point_magnitude = '0;
    logic signed [15:0] s_point_azimuth = '0;
    logic s_last_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_cluster_number;
    logic [6:0]  m_point_total;
    logic signed [15:0] m_mean_magnitude, m_mean_azimuth, m_centroid_x, m_centroid_y;
    logic [15:0] m_extent_x, m_extent_y;
    logic [16:0] m_mean_pair_distance;
    logic [1:0]  m_status;

    point_cluster_statistics DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    longint px[NPTS];
    longint py[NPTS];
    int     held;
    bit     dropped;
    longint acc_x, acc_y, acc_mag, acc_azi;
    longint lo_x, hi_x, lo_y, hi_y;
    logic [15:0] next_id;
    cluster_stats_t expected_stats[$];

    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    longint cycles = 0;

    function automatic void clear_cluster();
        held = 0;
        dropped = 1'b0;
        acc_x = 0; acc_y = 0; acc_mag = 0; acc_azi = 0;
        lo_x = 32767; lo_y = 32767;
        hi_x = -32768; hi_y = -32768;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic void predict_point(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] mag, logic signed [15:0] azi,
                                          logic last);
        cluster_stats_t r;
        longint dsum, dx, dy, n, pairs, mean_d;
        if (held < NPTS) begin
            px[held] = x;
            py[held] = y;
            held++;
            acc_x += x; acc_y += y; acc_mag += mag; acc_azi += azi;
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
        end else begin
            dropped = 1'b1;
        end
        if (!last) return;
        dsum = 0;
        for (int i = 0; i < held; i++)
            for (int j = i + 1; j < held; j++) begin
                dx = px[i] - px[j];
                dy = py[i] - py[j];
                dsum += int_sqrt(dx * dx + dy * dy);
            end
        n = held;
        pairs = n * (n - 1) / 2;
        mean_d = (pairs != 0) ? dsum / pairs : 0;
        r.cluster_number = next_id;
        r.point_total = n[6:0];
        r.mean_magnitude = 16'(acc_mag / n);
        r.mean_azimuth = 16'(acc_azi / n);
        r.centroid_x = 16'(acc_x / n);
        r.centroid_y = 16'(acc_y / n);
        r.extent_x = 16'(hi_x - lo_x);
        r.extent_y = 16'(hi_y - lo_y);
        r.mean_pair_distance = 17'(mean_d);
        r.status = dropped ? STATUS_OVERFLOW : (n == 1 ? STATUS_SINGLE : STATUS_OK);
        expected_stats.push_back(r);
        next_id++;
        clear_cluster();
    endfunction

    // valid stays high after a transaction until the next idle cycle or the next item
    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] mag, logic signed [15:0] azi, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_x_coord <= x;
        s_y_coord <= y;
        s_point_magnitude <= mag;
        s_point_azimuth <= azi;
        s_last_point <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_point(x, y, mag, azi, last);
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(31)) - 16'sd16;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_cluster(int npts);
        for (int i = 0; i < npts; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(), i == npts - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge aclk);
    endtask

    task automatic test_single_points();
        send_point(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
        send_point(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
        send_point(16'sd0, 16'sd0, -16'sd1, 16'sd1, 1'b1);
    endtask

    task automatic test_extreme_pairs();
        send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_point(-16'sd3, 16'sd5, -16'sd7, -16'sd1, 1'b0);
        send_point(16'sd2, -16'sd4, 16'sd0, -16'sd2, 1'b0);
        send_point(16'sd1, 16'sd1, -16'sd1, 16'sd0, 1'b1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < NPTS + 3; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(), i == NPTS + 2);
        for (int i = 0; i < NPTS; i++)
            send_point(16'(i), -16'(i), 16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_random(int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(NPTS + 4, 20) : $urandom_range(12, 1);
            send_cluster(n);
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        for (int i = 0; i < 6; i++) send_cluster(3);
        recv_hold = 1'b0;
        wait_drained();
        send_cluster(5);
        wait_drained();
        repeat (50) @(posedge aclk);
        send_cluster(2);
    endtask

    // receiver: random stalls, long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (!recv_hold) begin
                hold_cnt = 0;
            end else if (hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
            end
            m_ready <= !(recv_hold && hold_cnt < HOLD_CYCLES)
                       && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        cluster_stats_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_cluster_number, m_point_total, m_mean_magnitude, m_mean_azimuth,
                   m_centroid_x, m_centroid_y, m_extent_x, m_extent_y,
                   m_mean_pair_distance, m_status};
            if (expected_stats.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_stats.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        clear_cluster();
        next_id = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_points();
        test_extreme_pairs();
        test_overflow();
        test_backpressure();
        send_idle_pct = 19; recv_idle_pct = 56;
        test_random(440);
        send_idle_pct = 56; recv_idle_pct = 19;
        test_random(440);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(440);
        wait_drained();
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
